// ----- rtl/core/lobm_pkg.sv -----
package lobm_pkg;

    localparam int ORDERS    = 2048;
    localparam int SLOT_W    = $clog2(ORDERS);
    localparam int LINK_W    = SLOT_W + 1;
    localparam int LEVELS    = 1024;
    localparam int LVL_W     = $clog2(LEVELS);
    localparam int BOOK_AW   = LVL_W + 1;
    localparam int IDS       = 65536;
    localparam int ID_W      = $clog2(IDS);
    localparam int MAX_FILLS = 63;
    localparam int FILL_W    = $clog2(MAX_FILLS + 1);
    localparam int VOL_W     = 24;
    localparam int OWNER_W   = 16;
    localparam int CFG_W     = 11;
    localparam int DATA_W    = 72;

    localparam logic [LINK_W-1:0] NIL               = LINK_W'(ORDERS);
    localparam logic [CFG_W-1:0]  PRICE_LIMIT_RESET = CFG_W'(1024);

    typedef enum logic [2:0] {
        KIND_TRADE    = 3'd0,
        KIND_RESTED   = 3'd1,
        KIND_FILLED   = 3'd2,
        KIND_PRICE    = 3'd3,
        KIND_FULL     = 3'd4,
        KIND_CANCEL   = 3'd5,
        KIND_UNKNOWN  = 3'd6,
        KIND_LIMIT    = 3'd7
    } kind_t;

    typedef enum logic [1:0] {
        CL_ORDER  = 2'd0,
        CL_CANCEL = 2'd1,
        CL_REJECT = 2'd2
    } cls_t;

    typedef struct packed {
        cls_t               cls;
        logic               side;
        logic [OWNER_W-1:0] owner;
        logic [LVL_W-1:0]   price;
        logic [VOL_W-1:0]   volume;
        logic [ID_W-1:0]    order_ref;
    } cmd_t;

    typedef struct packed {
        logic [OWNER_W-1:0] owner;
        logic [ID_W-1:0]    book_id;
        logic [LVL_W-1:0]   level;
        logic               side;
        logic [VOL_W-1:0]   remaining;
        logic               used;
    } slot_rec_t;

    typedef struct packed {
        logic [LINK_W-1:0] head;
        logic [LINK_W-1:0] tail;
    } head_tail_t;

    typedef struct packed {
        kind_t              kind;
        logic [OWNER_W-1:0] counter_owner;
        logic [VOL_W-1:0]   amount;
        logic [LVL_W-1:0]   trade_level;
        logic [ID_W-1:0]    book_id;
        logic               last;
    } result_t;

endpackage

// ----- rtl/core/lobm_ram.sv -----
module lobm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/core/lobm_front.sv -----
module lobm_front import lobm_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [DATA_W-1:0] s_tdata,
    input  logic              s_tuser,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [CFG_W-1:0]  cfg_data,
    input  logic              hold,
    output logic              q_valid,
    input  logic              q_ready,
    output cmd_t              q_item
);

    logic [CFG_W-1:0] price_limit_reg;
    cmd_t             q_mem_reg [2];
    logic             wr_ptr_reg, rd_ptr_reg;
    logic [1:0]       cnt_reg;
    cmd_t             in_item;
    logic             push, pop;

    assign cfg_ready = 1'b1;

    always_comb begin
        in_item.side      = s_tdata[0];
        in_item.owner     = s_tdata[16:1];
        in_item.price     = s_tdata[26:17];
        in_item.volume    = s_tdata[50:27];
        in_item.order_ref = s_tdata[66:51];
        if (s_tuser) begin
            in_item.cls = CL_CANCEL;
        end else if ({1'b0, in_item.price} >= price_limit_reg) begin
            in_item.cls = CL_REJECT;
        end else begin
            in_item.cls = CL_ORDER;
        end
    end

    assign s_tready = (cnt_reg != 2'd2) && !hold;
    assign push     = s_tvalid && s_tready;
    assign q_valid  = cnt_reg != 2'd0;
    assign q_item   = q_mem_reg[rd_ptr_reg];
    assign pop      = q_valid && q_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            price_limit_reg <= PRICE_LIMIT_RESET;
            wr_ptr_reg      <= 1'b0;
            rd_ptr_reg      <= 1'b0;
            cnt_reg         <= 2'd0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                price_limit_reg <= cfg_data;
            end
            if (push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
        if (push) begin
            q_mem_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

// ----- rtl/core/lobm_back.sv -----
module lobm_back import lobm_pkg::*; (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    q_valid,
    output logic    q_ready,
    input  cmd_t    q_item,
    output logic    clearing,
    output logic    res_valid,
    input  logic    res_ready,
    output result_t res_data
);

    typedef enum logic [17:0] {
        ST_CLEAR     = 18'h00001,
        ST_IDLE      = 18'h00002,
        ST_CAN_MAP   = 18'h00004,
        ST_CAN_CHK   = 18'h00008,
        ST_UL_RD     = 18'h00010,
        ST_UL_BOOK   = 18'h00020,
        ST_UL_WR     = 18'h00040,
        ST_LVL       = 18'h00080,
        ST_HEAD      = 18'h00100,
        ST_SLOT      = 18'h00200,
        ST_FILL_RD   = 18'h00400,
        ST_FILL      = 18'h00800,
        ST_END       = 18'h01000,
        ST_POP       = 18'h02000,
        ST_REST_RD   = 18'h04000,
        ST_REST_WR   = 18'h08000,
        ST_REST_LINK = 18'h10000,
        ST_FINAL     = 18'h20000
    } state_t;

    state_t              st_reg, st_next;
    cmd_t                item_reg, item_next;
    logic [VOL_W-1:0]    vol_reg, vol_next;
    logic [FILL_W-1:0]   fills_reg, fills_next;
    logic [LVL_W-1:0]    lvl_reg, lvl_next;
    logic [LINK_W-1:0]   s_reg, s_next;
    logic [LINK_W-1:0]   nx_reg, nx_next;
    logic [LINK_W-1:0]   p_reg, p_next;
    logic [LINK_W-1:0]   n_reg, n_next;
    slot_rec_t           rec_reg, rec_next;
    logic [LINK_W-1:0]   free_count_reg, free_count_next;
    logic [LINK_W-1:0]   fresh_reg, fresh_next;
    logic [ID_W-1:0]     next_id_reg, next_id_next;
    logic [BOOK_AW-1:0]  clr_reg, clr_next;
    logic                is_cancel_reg, is_cancel_next;
    result_t             res_reg, res_next;
    result_t             out_reg, out_next;
    logic                out_valid_reg, out_valid_next;

    logic                can_emit;
    logic [LINK_W-1:0]   free_top;

    logic                dat_we;
    logic [SLOT_W-1:0]   dat_waddr, dat_raddr;
    slot_rec_t           dat_wdata, dat_rdata;
    logic                nxt_we;
    logic [SLOT_W-1:0]   nxt_waddr, nxt_raddr;
    logic [LINK_W-1:0]   nxt_wdata, nxt_rdata;
    logic                prv_we;
    logic [SLOT_W-1:0]   prv_waddr, prv_raddr;
    logic [LINK_W-1:0]   prv_wdata, prv_rdata;
    logic                bk_we;
    logic [BOOK_AW-1:0]  bk_waddr, bk_raddr;
    head_tail_t          bk_wdata, bk_rdata;
    logic                fs_we;
    logic [SLOT_W-1:0]   fs_waddr, fs_raddr;
    logic [SLOT_W-1:0]   fs_wdata, fs_rdata;
    logic                id_we;
    logic [ID_W-1:0]     id_waddr, id_raddr;
    logic [SLOT_W-1:0]   id_wdata, id_rdata;

    lobm_ram #(.WIDTH($bits(slot_rec_t)), .DEPTH(ORDERS)) u_dat (
        .aclk(aclk), .we(dat_we), .waddr(dat_waddr), .wdata(dat_wdata),
        .raddr(dat_raddr), .rdata(dat_rdata)
    );
    lobm_ram #(.WIDTH(LINK_W), .DEPTH(ORDERS)) u_nxt (
        .aclk(aclk), .we(nxt_we), .waddr(nxt_waddr), .wdata(nxt_wdata),
        .raddr(nxt_raddr), .rdata(nxt_rdata)
    );
    lobm_ram #(.WIDTH(LINK_W), .DEPTH(ORDERS)) u_prv (
        .aclk(aclk), .we(prv_we), .waddr(prv_waddr), .wdata(prv_wdata),
        .raddr(prv_raddr), .rdata(prv_rdata)
    );
    lobm_ram #(.WIDTH($bits(head_tail_t)), .DEPTH(2 * LEVELS)) u_book (
        .aclk(aclk), .we(bk_we), .waddr(bk_waddr), .wdata(bk_wdata),
        .raddr(bk_raddr), .rdata(bk_rdata)
    );
    lobm_ram #(.WIDTH(SLOT_W), .DEPTH(ORDERS)) u_free (
        .aclk(aclk), .we(fs_we), .waddr(fs_waddr), .wdata(fs_wdata),
        .raddr(fs_raddr), .rdata(fs_rdata)
    );
    lobm_ram #(.WIDTH(SLOT_W), .DEPTH(IDS)) u_ids (
        .aclk(aclk), .we(id_we), .waddr(id_waddr), .wdata(id_wdata),
        .raddr(id_raddr), .rdata(id_rdata)
    );

    assign can_emit  = !out_valid_reg || res_ready;
    assign free_top  = free_count_reg - LINK_W'(1);
    assign clearing  = (st_reg == ST_CLEAR);
    assign res_valid = out_valid_reg;
    assign res_data  = out_reg;

    always_comb begin
        st_next         = st_reg;
        item_next       = item_reg;
        vol_next        = vol_reg;
        fills_next      = fills_reg;
        lvl_next        = lvl_reg;
        s_next          = s_reg;
        nx_next         = nx_reg;
        p_next          = p_reg;
        n_next          = n_reg;
        rec_next        = rec_reg;
        free_count_next = free_count_reg;
        fresh_next      = fresh_reg;
        next_id_next    = next_id_reg;
        clr_next        = clr_reg;
        is_cancel_next  = is_cancel_reg;
        res_next        = res_reg;
        out_next        = out_reg;
        out_valid_next  = out_valid_reg && !res_ready;
        q_ready         = 1'b0;

        dat_we = 1'b0; dat_waddr = s_reg[SLOT_W-1:0]; dat_wdata = rec_reg;
        dat_raddr = s_reg[SLOT_W-1:0];
        nxt_we = 1'b0; nxt_waddr = s_reg[SLOT_W-1:0]; nxt_wdata = NIL;
        nxt_raddr = s_reg[SLOT_W-1:0];
        prv_we = 1'b0; prv_waddr = s_reg[SLOT_W-1:0]; prv_wdata = NIL;
        prv_raddr = s_reg[SLOT_W-1:0];
        bk_we = 1'b0; bk_waddr = clr_reg; bk_wdata = '{head: NIL, tail: NIL};
        bk_raddr = {rec_reg.side, rec_reg.level};
        fs_we = 1'b0; fs_waddr = free_count_reg[SLOT_W-1:0];
        fs_wdata = s_reg[SLOT_W-1:0]; fs_raddr = free_top[SLOT_W-1:0];
        id_we = 1'b0; id_waddr = next_id_reg; id_wdata = s_reg[SLOT_W-1:0];
        id_raddr = q_item.order_ref;

        case (st_reg)
            ST_CLEAR: begin
                bk_we    = 1'b1;
                clr_next = clr_reg + BOOK_AW'(1);
                if (clr_reg == {BOOK_AW{1'b1}}) begin
                    st_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                q_ready = 1'b1;
                if (q_valid) begin
                    item_next  = q_item;
                    vol_next   = q_item.volume;
                    fills_next = '0;
                    res_next   = '{kind: KIND_PRICE, counter_owner: '0,
                                   amount: q_item.volume, trade_level: '0,
                                   book_id: '0, last: 1'b1};
                    case (q_item.cls)
                        CL_CANCEL: st_next = ST_CAN_MAP;
                        CL_ORDER: begin
                            lvl_next = q_item.side ? LVL_W'(LEVELS - 1) : '0;
                            st_next  = (q_item.volume == '0) ? ST_END : ST_LVL;
                        end
                        default: st_next = ST_FINAL;
                    endcase
                end
            end
            ST_CAN_MAP: begin
                s_next    = {1'b0, id_rdata};
                dat_raddr = id_rdata;
                st_next   = ST_CAN_CHK;
            end
            ST_CAN_CHK: begin
                if (s_reg < fresh_reg && dat_rdata.used &&
                    dat_rdata.book_id == item_reg.order_ref) begin
                    is_cancel_next = 1'b1;
                    res_next = '{kind: KIND_CANCEL, counter_owner: '0,
                                 amount: dat_rdata.remaining,
                                 trade_level: dat_rdata.level,
                                 book_id: item_reg.order_ref, last: 1'b1};
                    st_next  = ST_UL_RD;
                end else begin
                    res_next = '{kind: KIND_UNKNOWN, counter_owner: '0, amount: '0,
                                 trade_level: '0, book_id: item_reg.order_ref,
                                 last: 1'b1};
                    st_next  = ST_FINAL;
                end
            end
            ST_UL_RD: begin
                st_next = ST_UL_BOOK;
            end
            ST_UL_BOOK: begin
                rec_next = dat_rdata;
                p_next   = prv_rdata;
                n_next   = nxt_rdata;
                bk_raddr = {dat_rdata.side, dat_rdata.level};
                st_next  = ST_UL_WR;
            end
            ST_UL_WR: begin
                bk_we         = 1'b1;
                bk_waddr      = {rec_reg.side, rec_reg.level};
                bk_wdata.head = p_reg[SLOT_W] ? n_reg : bk_rdata.head;
                bk_wdata.tail = n_reg[SLOT_W] ? p_reg : bk_rdata.tail;
                nxt_we        = !p_reg[SLOT_W];
                nxt_waddr     = p_reg[SLOT_W-1:0];
                nxt_wdata     = n_reg;
                prv_we        = !n_reg[SLOT_W];
                prv_waddr     = n_reg[SLOT_W-1:0];
                prv_wdata     = p_reg;
                dat_we        = 1'b1;
                dat_wdata     = rec_reg;
                dat_wdata.used = 1'b0;
                if (free_count_reg < LINK_W'(ORDERS)) begin
                    fs_we           = 1'b1;
                    free_count_next = free_count_reg + LINK_W'(1);
                end
                if (is_cancel_reg) begin
                    st_next = ST_FINAL;
                end else begin
                    s_next  = nx_reg;
                    st_next = ST_SLOT;
                end
            end
            ST_LVL: begin
                bk_raddr = {~item_reg.side, lvl_reg};
                st_next  = ST_HEAD;
            end
            ST_HEAD: begin
                s_next  = bk_rdata.head;
                st_next = ST_SLOT;
            end
            ST_SLOT: begin
                if (vol_reg == '0 || fills_reg >= FILL_W'(MAX_FILLS)) begin
                    st_next = ST_END;
                end else if (s_reg[SLOT_W]) begin
                    if (lvl_reg == item_reg.price) begin
                        st_next = ST_END;
                    end else begin
                        lvl_next = item_reg.side ? lvl_reg - LVL_W'(1)
                                                 : lvl_reg + LVL_W'(1);
                        st_next  = ST_LVL;
                    end
                end else begin
                    st_next = ST_FILL_RD;
                end
            end
            ST_FILL_RD: begin
                rec_next = dat_rdata;
                nx_next  = nxt_rdata;
                st_next  = ST_FILL;
            end
            ST_FILL: begin
                if (can_emit) begin
                    out_valid_next = 1'b1;
                    out_next = '{kind: KIND_TRADE, counter_owner: rec_reg.owner,
                                 amount: (vol_reg >= rec_reg.remaining) ?
                                         rec_reg.remaining : vol_reg,
                                 trade_level: lvl_reg, book_id: '0, last: 1'b0};
                    fills_next = fills_reg + FILL_W'(1);
                    if (vol_reg >= rec_reg.remaining) begin
                        vol_next       = vol_reg - rec_reg.remaining;
                        is_cancel_next = 1'b0;
                        st_next        = ST_UL_RD;
                    end else begin
                        dat_we              = 1'b1;
                        dat_wdata.remaining = rec_reg.remaining - vol_reg;
                        vol_next            = '0;
                        st_next             = ST_END;
                    end
                end
            end
            ST_END: begin
                res_next = '{kind: KIND_FILLED, counter_owner: '0, amount: '0,
                             trade_level: '0, book_id: '0, last: 1'b1};
                if (vol_reg == '0) begin
                    st_next = ST_FINAL;
                end else if (fills_reg >= FILL_W'(MAX_FILLS)) begin
                    res_next.kind   = KIND_LIMIT;
                    res_next.amount = vol_reg;
                    st_next         = ST_FINAL;
                end else if (free_count_reg != '0) begin
                    free_count_next = free_top;
                    st_next         = ST_POP;
                end else if (fresh_reg < LINK_W'(ORDERS)) begin
                    s_next     = fresh_reg;
                    fresh_next = fresh_reg + LINK_W'(1);
                    st_next    = ST_REST_RD;
                end else begin
                    res_next.kind   = KIND_FULL;
                    res_next.amount = vol_reg;
                    st_next         = ST_FINAL;
                end
            end
            ST_POP: begin
                s_next  = {1'b0, fs_rdata};
                st_next = ST_REST_RD;
            end
            ST_REST_RD: begin
                bk_raddr = {item_reg.side, item_reg.price};
                st_next  = ST_REST_WR;
            end
            ST_REST_WR: begin
                dat_we    = 1'b1;
                dat_wdata = '{owner: item_reg.owner, book_id: next_id_reg,
                              level: item_reg.price, side: item_reg.side,
                              remaining: vol_reg, used: 1'b1};
                prv_we    = 1'b1;
                prv_wdata = bk_rdata.tail;
                nxt_we    = 1'b1;
                bk_we     = 1'b1;
                bk_waddr  = {item_reg.side, item_reg.price};
                bk_wdata.head = bk_rdata.tail[SLOT_W] ? s_reg : bk_rdata.head;
                bk_wdata.tail = s_reg;
                id_we     = 1'b1;
                nx_next   = bk_rdata.tail;
                res_next  = '{kind: KIND_RESTED, counter_owner: '0, amount: vol_reg,
                              trade_level: item_reg.price, book_id: next_id_reg,
                              last: 1'b1};
                next_id_next = next_id_reg + ID_W'(1);
                st_next   = ST_REST_LINK;
            end
            ST_REST_LINK: begin
                nxt_we    = !nx_reg[SLOT_W];
                nxt_waddr = nx_reg[SLOT_W-1:0];
                nxt_wdata = s_reg;
                st_next   = ST_FINAL;
            end
            ST_FINAL: begin
                if (can_emit) begin
                    out_valid_next = 1'b1;
                    out_next       = res_reg;
                    st_next        = ST_IDLE;
                end
            end
            default: st_next = ST_CLEAR;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg         <= ST_CLEAR;
            clr_reg        <= '0;
            free_count_reg <= '0;
            fresh_reg      <= '0;
            next_id_reg    <= '0;
            out_valid_reg  <= 1'b0;
        end else begin
            st_reg         <= st_next;
            clr_reg        <= clr_next;
            free_count_reg <= free_count_next;
            fresh_reg      <= fresh_next;
            next_id_reg    <= next_id_next;
            out_valid_reg  <= out_valid_next;
        end
        item_reg      <= item_next;
        vol_reg       <= vol_next;
        fills_reg     <= fills_next;
        lvl_reg       <= lvl_next;
        s_reg         <= s_next;
        nx_reg        <= nx_next;
        p_reg         <= p_next;
        n_reg         <= n_next;
        rec_reg       <= rec_next;
        is_cancel_reg <= is_cancel_next;
        res_reg       <= res_next;
        out_reg       <= out_next;
    end

    a_final_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (st_reg == ST_FINAL && can_emit) |=> (out_valid_reg && out_reg.last))
        else $error("final word without last");

    a_trade_not_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (st_reg == ST_FILL && can_emit) |=>
        (out_valid_reg && !out_reg.last && out_reg.kind == KIND_TRADE))
        else $error("trade word malformed");

    a_id_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (st_reg == ST_REST_WR) |=> (next_id_reg == ID_W'($past(next_id_reg) + 1)))
        else $error("order id not advanced");

    a_clear_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (st_reg == ST_CLEAR && clr_reg == {BOOK_AW{1'b1}}) |=> (st_reg == ST_IDLE))
        else $error("book clear did not finish");

    a_unlink_ret: assert property (@(posedge aclk) disable iff (!aresetn)
        (st_reg == ST_UL_WR && !is_cancel_reg) |=> (st_reg == ST_SLOT))
        else $error("unlink returned to wrong state");

endmodule

// ----- rtl/core/limit_order_book_matcher.sv -----
// channel   dir  tdata fields (lsb up)                          tuser   tlast
// s_        in   side, owner, price, volume, order_ref          cmd     -
// m_        out  counter_owner, amount, trade_level, book_id    kind    last
// cfg_      in   price_limit                                    -       -
//
// A cancel looks up the id and unlinks the order when it is found. A new order
// scans price levels in turn, fills against the orders resting at each and rests
// what is left, on a freed slot if there is one; both are bound by the single read
// port of each slot and level table. After reset the level table is cleared, one
// entry a cycle, with s_tready low. Input queue holds two words; output register
// lets the next word be taken while a result waits.
module limit_order_book_matcher import lobm_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [DATA_W-1:0] s_tdata,   // side, owner, price, volume, order_ref
    input  logic              s_tuser,   // cmd
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [DATA_W-1:0] m_tdata,   // counter_owner, amount, trade_level, book_id
    output logic [2:0]        m_tuser,   // kind
    output logic              m_tlast,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [CFG_W-1:0]  cfg_data
);

    logic    q_valid, q_ready, hold;
    cmd_t    q_item;
    result_t res;

    lobm_front u_front (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .hold(hold), .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item)
    );

    lobm_back u_back (
        .aclk(aclk), .aresetn(aresetn),
        .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item), .clearing(hold),
        .res_valid(m_tvalid), .res_ready(m_tready), .res_data(res)
    );

    assign m_tdata = {6'b0, res.book_id, res.trade_level, res.amount, res.counter_owner};
    assign m_tuser = res.kind;
    assign m_tlast = res.last;

endmodule

// ----- test/tb_limit_order_book_matcher.sv -----
module tb_limit_order_book_matcher;
    import lobm_pkg::*;

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [DATA_W-1:0] s_tdata = '0;
    logic              s_tuser = 1'b0;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [DATA_W-1:0] m_tdata;
    logic [2:0]        m_tuser;
    logic              m_tlast;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [CFG_W-1:0]  cfg_data = '0;

    localparam bit CMD_ORDER  = 1'b0;
    localparam bit CMD_CANCEL = 1'b1;
    localparam bit SIDE_BUY   = 1'b0;
    localparam bit SIDE_SELL  = 1'b1;
    localparam int NULL_SLOT  = ORDERS;

    limit_order_book_matcher uut (.*);

    always #6 aclk = ~aclk;

    // book mirror
    logic [OWNER_W-1:0] bk_owner [ORDERS];
    logic [ID_W-1:0]    bk_id    [ORDERS];
    int                 bk_level [ORDERS];
    bit                 bk_side  [ORDERS];
    int                 bk_rem   [ORDERS];
    int                 bk_next  [ORDERS];
    int                 bk_prev  [ORDERS];
    bit                 bk_used  [ORDERS];
    int                 free_slots [$];
    int                 fresh_next;
    int                 bid_head [LEVELS], bid_tail [LEVELS];
    int                 ask_head [LEVELS], ask_tail [LEVELS];
    int                 id_slot  [IDS];
    int                 issued_ids;
    int                 next_book_id;
    int                 price_limit;

    result_t pending_results [$];
    int      fail_count = 0;
    int      send_gap_max = 14;
    int      recv_gap_max = 14;

    function automatic int level_head(bit sd, int lvl);
        return sd ? ask_head[lvl] : bid_head[lvl];
    endfunction

    function automatic void set_head(bit sd, int lvl, int v);
        if (sd) ask_head[lvl] = v; else bid_head[lvl] = v;
    endfunction

    function automatic void set_tail(bit sd, int lvl, int v);
        if (sd) ask_tail[lvl] = v; else bid_tail[lvl] = v;
    endfunction

    function automatic void expect_word(kind_t k, int cown, int amt, int lvl, int id, bit lst);
        result_t r;
        r.kind          = k;
        r.counter_owner = OWNER_W'(cown);
        r.amount        = VOL_W'(amt);
        r.trade_level   = LVL_W'(lvl);
        r.book_id       = ID_W'(id);
        r.last          = lst;
        pending_results.insert(pending_results.size(), r);
    endfunction

    function automatic void unlink_order(int s);
        int p, n, lvl;
        bit sd;
        lvl = bk_level[s];
        sd  = bk_side[s];
        p   = bk_prev[s];
        n   = bk_next[s];
        if (p != NULL_SLOT) bk_next[p] = n; else set_head(sd, lvl, n);
        if (n != NULL_SLOT) bk_prev[n] = p; else set_tail(sd, lvl, p);
        bk_used[s] = 1'b0;
        bk_next[s] = NULL_SLOT;
        bk_prev[s] = NULL_SLOT;
        free_slots.insert(free_slots.size(), s);
    endfunction

    function automatic void book_reset();
        for (int i = 0; i < ORDERS; i++) begin
            bk_used[i] = 1'b0;
            bk_next[i] = NULL_SLOT;
            bk_prev[i] = NULL_SLOT;
        end
        for (int i = 0; i < LEVELS; i++) begin
            bid_head[i] = NULL_SLOT; bid_tail[i] = NULL_SLOT;
            ask_head[i] = NULL_SLOT; ask_tail[i] = NULL_SLOT;
        end
        free_slots.delete();
        fresh_next   = 0;
        issued_ids   = 0;
        next_book_id = 0;
        price_limit  = 1024;
    endfunction

    function automatic void book_predict(bit cmd, bit sd, int owner, int price, int vol, int ref_id);
        int s, nx, r, fills, lvl, t;
        fills = 0;
        if (cmd == CMD_CANCEL) begin
            s = id_slot[ref_id];
            if (ref_id < issued_ids && s != NULL_SLOT && bk_used[s] && bk_id[s] == ID_W'(ref_id)) begin
                expect_word(KIND_CANCEL, 0, bk_rem[s], bk_level[s], ref_id, 1'b1);
                unlink_order(s);
            end else begin
                expect_word(KIND_UNKNOWN, 0, 0, 0, ref_id, 1'b1);
            end
            return;
        end
        if (price >= price_limit) begin
            expect_word(KIND_PRICE, 0, vol, 0, 0, 1'b1);
            return;
        end
        for (int i = 0; i < LEVELS && vol > 0 && fills < MAX_FILLS; i++) begin
            lvl = sd ? LEVELS - 1 - i : i;
            if (!sd && lvl > price) break;
            if (sd && lvl < price) break;
            s = level_head(!sd, lvl);
            while (s != NULL_SLOT && vol > 0 && fills < MAX_FILLS) begin
                r = bk_rem[s];
                if (vol >= r) begin
                    nx = bk_next[s];
                    expect_word(KIND_TRADE, bk_owner[s], r, lvl, 0, 1'b0);
                    vol -= r;
                    unlink_order(s);
                    s = nx;
                end else begin
                    expect_word(KIND_TRADE, bk_owner[s], vol, lvl, 0, 1'b0);
                    bk_rem[s] = r - vol;
                    vol = 0;
                end
                fills++;
            end
        end
        if (vol == 0) begin
            expect_word(KIND_FILLED, 0, 0, 0, 0, 1'b1);
            return;
        end
        if (fills >= MAX_FILLS) begin
            expect_word(KIND_LIMIT, 0, vol, 0, 0, 1'b1);
            return;
        end
        if (free_slots.size() > 0) begin
            s = free_slots[free_slots.size() - 1];
            free_slots.delete(free_slots.size() - 1);
        end
        else if (fresh_next < ORDERS) s = fresh_next++;
        else begin
            expect_word(KIND_FULL, 0, vol, 0, 0, 1'b1);
            return;
        end
        t = sd ? ask_tail[price] : bid_tail[price];
        bk_owner[s] = OWNER_W'(owner);
        bk_id[s]    = ID_W'(next_book_id);
        bk_level[s] = price;
        bk_side[s]  = sd;
        bk_rem[s]   = vol;
        bk_used[s]  = 1'b1;
        bk_prev[s]  = t;
        bk_next[s]  = NULL_SLOT;
        if (t != NULL_SLOT) bk_next[t] = s; else set_head(sd, price, s);
        set_tail(sd, price, s);
        id_slot[next_book_id] = s;
        expect_word(KIND_RESTED, 0, vol, price, next_book_id, 1'b1);
        next_book_id = (next_book_id + 1) % IDS;
        if (issued_ids < IDS) issued_ids++;
    endfunction

    // one input word; the predictor runs on acceptance
    task automatic send_word(bit cmd, bit sd, int owner, int price, int vol, int ref_id);
        repeat ($urandom_range(send_gap_max)) @(negedge aclk);
        s_tvalid = 1'b1;
        s_tuser  = cmd;
        s_tdata  = '0;
        s_tdata[0]     = sd;
        s_tdata[16:1]  = OWNER_W'(owner);
        s_tdata[26:17] = LVL_W'(price);
        s_tdata[50:27] = VOL_W'(vol);
        s_tdata[66:51] = ID_W'(ref_id);
        do @(posedge aclk); while (!s_tready);
        book_predict(cmd, sd, owner, price, vol, ref_id);
        @(negedge aclk);
        s_tvalid = 1'b0;
    endtask

    task automatic wait_drained();
        while (pending_results.size() != 0) @(negedge aclk);
        repeat (20) @(negedge aclk);
    endtask

    task automatic write_price_limit(int v);
        wait_drained();
        cfg_valid = 1'b1;
        cfg_data  = CFG_W'(v);
        do @(posedge aclk); while (!cfg_ready);
        price_limit = v;
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    always begin
        @(negedge aclk);
        if (aresetn) begin
            m_tready = 1'b0;
            repeat ($urandom_range(recv_gap_max)) @(negedge aclk);
            m_tready = 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    always @(posedge aclk) begin
        result_t e;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                $error("unexpected word: kind %0d", m_tuser);
                fail_count++;
            end else begin
                e = pending_results.pop_front();
                if (m_tuser !== e.kind) begin
                    $error("kind: expected %0d, got %0d", e.kind, m_tuser); fail_count++;
                end
                if (m_tdata[15:0] !== e.counter_owner) begin
                    $error("counter_owner: expected %0d, got %0d", e.counter_owner,
                           m_tdata[15:0]);
                    fail_count++;
                end
                if (m_tdata[39:16] !== e.amount) begin
                    $error("amount: expected %0d, got %0d", e.amount, m_tdata[39:16]);
                    fail_count++;
                end
                if (m_tdata[49:40] !== e.trade_level) begin
                    $error("trade_level: expected %0d, got %0d", e.trade_level,
                           m_tdata[49:40]);
                    fail_count++;
                end
                if (m_tdata[65:50] !== e.book_id) begin
                    $error("book_id: expected %0d, got %0d", e.book_id, m_tdata[65:50]);
                    fail_count++;
                end
                if (m_tlast !== e.last) begin
                    $error("last: expected %0d, got %0d", e.last, m_tlast); fail_count++;
                end
            end
        end
    end

    task automatic test_edges();
        int id0;
        send_word(CMD_ORDER, SIDE_BUY, 0, 0, 1, 16'hffff);
        id0 = next_book_id - 1;
        send_word(CMD_ORDER, SIDE_SELL, 16'hffff, 1023, 24'hffffff, 0);
        send_word(CMD_ORDER, SIDE_BUY, 16'h1234, 1023, 0, 0);
        send_word(CMD_ORDER, SIDE_BUY, 16'h5555, 1023, 100, 0);
        send_word(CMD_ORDER, SIDE_SELL, 16'haaaa, 0, 3, 0);
        send_word(CMD_ORDER, SIDE_BUY, 7, 600, 40, 0);
        send_word(CMD_ORDER, SIDE_BUY, 8, 600, 50, 0);
        send_word(CMD_ORDER, SIDE_SELL, 9, 600, 60, 0);
        send_word(CMD_CANCEL, SIDE_SELL, 16'hffff, 1023, 24'hffffff, next_book_id - 2);
        send_word(CMD_CANCEL, SIDE_BUY, 0, 0, 0, next_book_id - 2);
        send_word(CMD_CANCEL, SIDE_BUY, 0, 0, 0, id0);
        send_word(CMD_ORDER, SIDE_BUY, 1, 1023, 24'hffffff, 0);
        send_word(CMD_CANCEL, SIDE_BUY, 0, 0, 0, 1);
    endtask

    task automatic test_price_limit();
        write_price_limit(1);
        send_word(CMD_ORDER, SIDE_SELL, 3, 0, 5, 0);
        send_word(CMD_ORDER, SIDE_BUY, 4, 1, 5, 0);
        send_word(CMD_ORDER, SIDE_BUY, 4, 1023, 24'hffffff, 0);
        send_word(CMD_ORDER, SIDE_BUY, 5, 0, 2, 0);
        write_price_limit(300);
        send_word(CMD_ORDER, SIDE_SELL, 6, 299, 9, 0);
        send_word(CMD_ORDER, SIDE_SELL, 6, 300, 9, 0);
        write_price_limit(1024);
    endtask

    task automatic test_fill_limit();
        for (int i = 0; i < MAX_FILLS + 2; i++)
            send_word(CMD_ORDER, SIDE_SELL, 100 + i, 7, 1, 0);
        send_word(CMD_ORDER, SIDE_BUY, 77, 7, 500, 0);
        send_word(CMD_ORDER, SIDE_BUY, 78, 7, 1, 0);
        send_word(CMD_ORDER, SIDE_BUY, 79, 7, 5, 0);
        send_word(CMD_CANCEL, SIDE_BUY, 0, 0, 0, next_book_id - 1);
    endtask

    task automatic test_random(int n);
        int sel, price, vol, ref_id;
        for (int i = 0; i < n; i++) begin
            if (i == 0) begin send_gap_max = 0; recv_gap_max = 0; end
            if (i == 60) begin send_gap_max = 14; recv_gap_max = 14; end
            if (i == 220) begin send_gap_max = 0; end
            if (i == 270) begin send_gap_max = 14; recv_gap_max = 0; end
            sel = $urandom_range(99);
            if (sel < 20 && issued_ids > 0) begin
                ref_id = issued_ids - 1 - $urandom_range(issued_ids > 30 ? 30 : issued_ids - 1);
                send_word(CMD_CANCEL, $urandom_range(1), $urandom, $urandom, $urandom, ref_id);
            end else begin
                price = (sel < 90) ? $urandom_range(530, 490) : $urandom_range(1023);
                vol   = (sel < 85) ? $urandom_range(60, 1) :
                        (sel < 93) ? $urandom_range(24'hffffff) : 0;
                send_word(CMD_ORDER, $urandom_range(1), $urandom_range(16'hffff), price, vol,
                          $urandom_range(16'hffff));
            end
        end
    endtask

    initial begin
        book_reset();
        repeat (10) @(negedge aclk);
        aresetn = 1'b1;
        test_edges();
        test_price_limit();
        test_fill_limit();
        test_random(320);
        wait_drained();
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial begin
        #120000000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
